>>> hw/rtl/scph_pkg.sv
package scph_pkg;

   localparam int FRAC_BITS = 16;
   localparam int CW = 32;
   localparam int DW = 33;
   localparam int PW = 66;
   localparam int AW = 68;

   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_END = 2'd1;
   localparam logic [1:0] MODE_MID = 2'd2;

   typedef struct packed {
      logic signed [CW-1:0] start_x;
      logic signed [CW-1:0] start_y;
      logic signed [CW-1:0] start_z;
      logic signed [CW-1:0] end_x;
      logic signed [CW-1:0] end_y;
      logic signed [CW-1:0] end_z;
      logic signed [CW-1:0] point_x;
      logic signed [CW-1:0] point_y;
      logic signed [CW-1:0] point_z;
      logic [30:0] radius;
   } req_type;

   typedef struct packed {
      logic signed [CW-1:0] near_x;
      logic signed [CW-1:0] near_y;
      logic signed [CW-1:0] near_z;
      logic hit;
      logic degenerate;
   } rsp_type;

endpackage

>>> hw/rtl/scph_stream_if.sv
interface scph_req_if;
   logic valid;
   logic ready;
   scph_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface scph_rsp_if;
   logic valid;
   logic ready;
   scph_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/segment_closest_point_hit.sv
// segment_closest_point_hit
// req: segment start/end, query point and radius, signed fixed point
// rsp: closest point on the segment, hit flag, degenerate flag
// fully pipelined, one transfer per cycle in each direction unless the receiver stalls
// pipeline stages in order (Q16.16 by default): difference, products,
// sums and mode, FRAC_BITS divider stages (one quotient bit each),
// interpolation product, point, distance products, distance sum
// the whole pipeline advances when the output register is empty or taken;
// a receiver stall holds every stage, nothing is lost or repeated
// reset clears all valid bits; payload registers are not reset
// the block takes a request whenever the output stage can move
// radius squared is compared exactly against the squared distance
// a zero length segment returns the start with degenerate set
module segment_closest_point_hit (
   input logic clock,
   input logic reset,
   scph_req_if.sink req,
   scph_rsp_if.source rsp
);
   localparam int CW = scph_pkg::CW;
   localparam int DW = scph_pkg::DW;
   localparam int PW = scph_pkg::PW;
   localparam int AW = scph_pkg::AW;
   localparam int N = scph_pkg::FRAC_BITS;
   localparam int DN = N + 1;

   logic adv;
   assign adv = !rsp.valid || rsp.ready;
   assign req.ready = adv;

   // stage 1: differences
   logic v1_ff;
   scph_pkg::req_type r1_ff;
   logic signed [DW-1:0] ab1_ff [3], ap1_ff [3];
   logic signed [CW-1:0] s_in [3], e_in [3], p_in [3];
   assign s_in = '{req.data.start_x, req.data.start_y, req.data.start_z};
   assign e_in = '{req.data.end_x, req.data.end_y, req.data.end_z};
   assign p_in = '{req.data.point_x, req.data.point_y, req.data.point_z};

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req.valid;
      if (adv) begin
         r1_ff <= req.data;
         for (int i = 0; i < 3; i++) begin
            ab1_ff[i] <= DW'(e_in[i]) - DW'(s_in[i]);
            ap1_ff[i] <= DW'(p_in[i]) - DW'(s_in[i]);
         end
      end
   end

   // stage 2: products
   logic v2_ff;
   scph_pkg::req_type r2_ff;
   logic signed [DW-1:0] ab2_ff [3];
   logic signed [PW-1:0] dp2_ff [3], lp2_ff [3];
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
      if (adv) begin
         r2_ff <= r1_ff;
         for (int i = 0; i < 3; i++) begin
            ab2_ff[i] <= ab1_ff[i];
            dp2_ff[i] <= ap1_ff[i] * ab1_ff[i];
            lp2_ff[i] <= ab1_ff[i] * ab1_ff[i];
         end
      end
   end

   // stage 3: sums and mode
   logic signed [AW-1:0] dot_c, len_c;
   assign dot_c = AW'(dp2_ff[0]) + AW'(dp2_ff[1]) + AW'(dp2_ff[2]);
   assign len_c = AW'(lp2_ff[0]) + AW'(lp2_ff[1]) + AW'(lp2_ff[2]);
   logic [1:0] mode_c;
   always_comb begin
      if (len_c == '0 || dot_c[AW-1] || dot_c == '0) mode_c = scph_pkg::MODE_START;
      else if (dot_c >= len_c) mode_c = scph_pkg::MODE_END;
      else mode_c = scph_pkg::MODE_MID;
   end

   logic v3_ff;
   scph_pkg::req_type r3_ff;
   logic signed [DW-1:0] ab3_ff [3];
   logic [1:0] mode3_ff;
   logic deg3_ff;
   logic [AW-1:0] dot3_ff, len3_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
      if (adv) begin
         r3_ff <= r2_ff;
         ab3_ff <= ab2_ff;
         mode3_ff <= mode_c;
         deg3_ff <= len_c == '0;
         dot3_ff <= (mode_c == scph_pkg::MODE_MID) ? dot_c : '0;
         len3_ff <= (mode_c == scph_pkg::MODE_MID) ? len_c : AW'(1);
      end
   end

   // divider with side data delay line
   logic vd;
   logic [N-1:0] tq;
   scph_divider u_div (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(v3_ff), .in_num(dot3_ff), .in_den(len3_ff),
      .out_valid(vd), .out_q(tq)
   );

   scph_pkg::req_type rd_ff [N];
   logic signed [DW-1:0] abd_ff [N][3];
   logic [1:0] moded_ff [N];
   logic degd_ff [N];
   always_ff @(posedge clock) begin
      if (adv) begin
         rd_ff[0] <= r3_ff;
         abd_ff[0] <= ab3_ff;
         moded_ff[0] <= mode3_ff;
         degd_ff[0] <= deg3_ff;
         for (int k = 1; k < N; k++) begin
            rd_ff[k] <= rd_ff[k-1];
            abd_ff[k] <= abd_ff[k-1];
            moded_ff[k] <= moded_ff[k-1];
            degd_ff[k] <= degd_ff[k-1];
         end
      end
   end

   // stage 4: ab * tq
   logic v4_ff;
   scph_pkg::req_type r4_ff;
   logic [1:0] mode4_ff;
   logic deg4_ff;
   logic signed [DW+DN-1:0] m4_ff [3];
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= vd;
      if (adv) begin
         r4_ff <= rd_ff[N-1];
         mode4_ff <= moded_ff[N-1];
         deg4_ff <= degd_ff[N-1];
         for (int i = 0; i < 3; i++)
            m4_ff[i] <= abd_ff[N-1][i] * $signed({1'b0, tq});
      end
   end

   // stage 5: closest point
   logic signed [CW-1:0] s4 [3], e4 [3], p4 [3];
   assign s4 = '{r4_ff.start_x, r4_ff.start_y, r4_ff.start_z};
   assign e4 = '{r4_ff.end_x, r4_ff.end_y, r4_ff.end_z};
   assign p4 = '{r4_ff.point_x, r4_ff.point_y, r4_ff.point_z};

   logic v5_ff, deg5_ff;
   logic [30:0] rad5_ff;
   logic signed [CW-1:0] n5_ff [3];
   logic signed [DW-1:0] d5_ff [3];
   logic signed [CW-1:0] n_c [3];
   logic signed [DW+DN-1:0] sh_c [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sh_c[i] = m4_ff[i] >>> N;
         case (mode4_ff)
            scph_pkg::MODE_END: n_c[i] = e4[i];
            scph_pkg::MODE_MID: n_c[i] = s4[i] + CW'(sh_c[i]);
            default: n_c[i] = s4[i];
         endcase
      end
   end
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (adv) v5_ff <= v4_ff;
      if (adv) begin
         deg5_ff <= deg4_ff;
         rad5_ff <= r4_ff.radius;
         for (int i = 0; i < 3; i++) begin
            n5_ff[i] <= n_c[i];
            d5_ff[i] <= DW'(n_c[i]) - DW'(p4[i]);
         end
      end
   end

   // stage 6: squares
   logic v6_ff, deg6_ff;
   logic signed [CW-1:0] n6_ff [3];
   logic [PW-1:0] q6_ff [3];
   logic [61:0] rr6_ff;
   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else if (adv) v6_ff <= v5_ff;
      if (adv) begin
         deg6_ff <= deg5_ff;
         n6_ff <= n5_ff;
         rr6_ff <= rad5_ff * rad5_ff;
         for (int i = 0; i < 3; i++)
            q6_ff[i] <= PW'(d5_ff[i]) * PW'(d5_ff[i]);
      end
   end

   // stage 7: output register
   logic [AW-1:0] h2_c;
   assign h2_c = AW'(q6_ff[0]) + AW'(q6_ff[1]) + AW'(q6_ff[2]);
   logic v7_ff;
   scph_pkg::rsp_type o_ff;
   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else if (adv) v7_ff <= v6_ff;
      if (adv) begin
         o_ff.near_x <= n6_ff[0];
         o_ff.near_y <= n6_ff[1];
         o_ff.near_z <= n6_ff[2];
         o_ff.hit <= AW'(rr6_ff) >= h2_c;
         o_ff.degenerate <= deg6_ff;
      end
   end

   assign rsp.valid = v7_ff;
   assign rsp.data = o_ff;
endmodule

>>> hw/rtl/scph_divider.sv
module scph_divider (
   input  logic clock,
   input  logic reset,
   input  logic adv,
   input  logic in_valid,
   input  logic [scph_pkg::AW-1:0] in_num,
   input  logic [scph_pkg::AW-1:0] in_den,
   output logic out_valid,
   output logic [scph_pkg::FRAC_BITS-1:0] out_q
);
   // one quotient bit per stage, restoring, D < L
   localparam int N = scph_pkg::FRAC_BITS;
   localparam int AW = scph_pkg::AW;

   logic [N:1] vld_ff;
   logic [AW-1:0] rem_ff [1:N-1];
   logic [AW-1:0] den_ff [1:N-1];
   logic [N-1:0] q_ff [1:N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic vld_c;
      logic [AW-1:0] rem_c;
      logic [AW-1:0] den_c;
      logic [N-1:0] q_c;
      logic [AW:0] sh;
      logic ge;
      if (k == 0) begin : g_first
         assign vld_c = in_valid;
         assign rem_c = in_num;
         assign den_c = in_den;
         assign q_c = '0;
      end else begin : g_next
         assign vld_c = vld_ff[k];
         assign rem_c = rem_ff[k];
         assign den_c = den_ff[k];
         assign q_c = q_ff[k];
      end
      assign sh = {rem_c, 1'b0};
      assign ge = sh >= {1'b0, den_c};
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[k+1] <= vld_c;
         end
         if (adv) begin
            q_ff[k+1] <= {q_c[N-2:0], ge};
         end
      end
      if (k < N - 1) begin : g_carry
         logic [AW:0] nxt_c;
         assign nxt_c = ge ? sh - {1'b0, den_c} : sh;
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k+1] <= nxt_c[AW-1:0];
               den_ff[k+1] <= den_c;
            end
         end
      end
   end

   assign out_valid = vld_ff[N];
   assign out_q = q_ff[N];
endmodule
